[hdl/xcr_pkg.sv]
`timescale 1ns / 1ps
// xcr_pkg: shared types, codes and constants of the xmodem-crc receiver
// depends on nothing; every other file of the block but xcr_ifs imports it
package xcr_pkg;

  // payload length of one packet and queue geometry
  localparam int PAYLOAD_BYTES = 128;
  localparam int QDEPTH        = 4;
  localparam int QAW           = 2;

  // protocol bytes
  localparam logic [7:0] B_SOH = 8'h01;
  localparam logic [7:0] B_EOT = 8'h04;
  localparam logic [7:0] B_ACK = 8'h06;
  localparam logic [7:0] B_NAK = 8'h15;
  localparam logic [7:0] B_CAN = 8'h18;
  localparam logic [7:0] B_C   = 8'h43;

  // crc-16/xmodem polynomial
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // request opcodes on the command channel
  localparam logic [2:0] OP_BYTE   = 3'd0;
  localparam logic [2:0] OP_TICK   = 3'd1;
  localparam logic [2:0] OP_BEGIN  = 3'd2;
  localparam logic [2:0] OP_NEXT   = 3'd3;
  localparam logic [2:0] OP_CANCEL = 3'd4;

  // completion status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_EOT          = 3'd1;
  localparam logic [2:0] ST_CAN          = 3'd2;
  localparam logic [2:0] ST_ABORT        = 3'd3;
  localparam logic [2:0] ST_INIT_TIMEOUT = 3'd4;

  // register indexes on the apb port
  localparam logic [1:0] REG_PACKET_TO = 2'd0;
  localparam logic [1:0] REG_DATA_TO   = 2'd1;
  localparam logic [1:0] REG_PURGE_TO  = 2'd2;
  localparam logic [1:0] REG_RETRY_LIM = 2'd3;

  // classified request kind
  typedef enum logic [2:0] {
    K_BYTE,
    K_TICK,
    K_BEGIN,
    K_NEXT,
    K_CANCEL
  } kind_t;

  // receiver phase
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PURGE,
    PH_WAIT_SOH,
    PH_NUM,
    PH_NUM_COMP,
    PH_PAYLOAD,
    PH_CRC_HI,
    PH_CRC_LO
  } phase_t;

  // queue entry: data is the received byte or the awaited packet number
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } item_t;

  // one result
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       buf_write;
    logic [6:0] buf_index;
    logic [7:0] buf_byte;
    logic       done_res;
    logic [2:0] status;
  } res_t;

  // configuration registers
  typedef struct packed {
    logic [15:0] packet_timeout_ms;
    logic [15:0] data_timeout_ms;
    logic [15:0] purge_timeout_ms;
    logic [7:0]  retry_limit;
  } cfg_t;

  // engine status seen by the top level
  typedef struct packed {
    logic pop;
    logic idle;
  } eng_stat_t;

endpackage

[hdl/xcr_ifs.sv]
`timescale 1ns / 1ps
// xcr_ifs: valid/ready channel interfaces for commands and results
// depends on nothing
interface xcr_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] rx_byte;
  logic [7:0] expected_number;

  modport source (output valid, output opcode, output rx_byte, output expected_number,
                  input ready);
  modport sink (input valid, input opcode, input rx_byte, input expected_number,
                output ready);
endinterface

interface xcr_res_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       buf_write;
  logic [6:0] buf_index;
  logic [7:0] buf_byte;
  logic       done_res;
  logic [2:0] status;

  modport source (output valid, output tx_valid, output tx_byte, output buf_write,
                  output buf_index, output buf_byte, output done_res, output status,
                  input ready);
  modport sink (input valid, input tx_valid, input tx_byte, input buf_write,
                input buf_index, input buf_byte, input done_res, input status,
                output ready);
endinterface

[hdl/xmodem_crc_receiver.sv]
`timescale 1ns / 1ps
// xmodem_crc_receiver: receiving side of xmodem-crc, 128-byte packets
// depends on xcr_pkg, xcr_ifs, xcr_front, xcr_queue and xcr_engine
//
//  port   | dir | handshake           | payload
//  cmd    | in  | valid / ready       | opcode, rx_byte, expected_number
//  res    | out | valid / ready       | tx_*, buf_*, done_res, status
//  apb    | in  | psel/penable/pready | paddr, pwdata, prdata
//
// one request per cycle sustained while the result sink is ready; the engine
// finishes each request as it takes it, with its byte crc worked in that same cycle
// an accepted request is written into the queue; the engine takes it from the head
// and loads the result register; a four-entry queue sits in between
// a stalled result holds the engine, the queue absorbs four more requests
// synchronous reset clears the phase, the queue and the result valid flag;
// registers return to 1000, 100, 100 and 10
module xmodem_crc_receiver
  import xcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  xcr_cmd_if.sink     cmd,
  xcr_res_if.source   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t      cfg;
  logic      q_ready;
  logic      push;
  item_t     entry;
  logic      head_valid;
  item_t     head;
  eng_stat_t stat;
  logic      cfg_wr;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.packet_timeout_ms <= 16'd1000;
      cfg.data_timeout_ms   <= 16'd100;
      cfg.purge_timeout_ms  <= 16'd100;
      cfg.retry_limit       <= 8'd10;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_PACKET_TO: cfg.packet_timeout_ms <= pwdata[15:0];
        REG_DATA_TO:   cfg.data_timeout_ms   <= pwdata[15:0];
        REG_PURGE_TO:  cfg.purge_timeout_ms  <= pwdata[15:0];
        REG_RETRY_LIM: cfg.retry_limit       <= pwdata[7:0];
        default:       cfg.retry_limit       <= cfg.retry_limit;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[3:2])
      REG_PACKET_TO: prdata = {16'd0, cfg.packet_timeout_ms};
      REG_DATA_TO:   prdata = {16'd0, cfg.data_timeout_ms};
      REG_PURGE_TO:  prdata = {16'd0, cfg.purge_timeout_ms};
      REG_RETRY_LIM: prdata = {24'd0, cfg.retry_limit};
      default:       prdata = '0;
    endcase
  end

  // request classification
  xcr_front u_front (
    .cmd     (cmd),
    .q_ready (q_ready),
    .push    (push),
    .entry   (entry)
  );

  // request queue
  xcr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (entry),
    .not_full   (q_ready),
    .pop        (stat.pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // protocol engine
  xcr_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .stat       (stat),
    .res        (res)
  );

  // cancel always leaves the receiver idle
  a_cancel_idle: assert property (@(posedge clk) disable iff (rst)
    stat.pop && head.kind == K_CANCEL |=> stat.idle)
    else $error("receiver not idle after cancel");

  // begin always starts a purge
  a_begin_busy: assert property (@(posedge clk) disable iff (rst)
    stat.pop && head.kind == K_BEGIN |=> !stat.idle)
    else $error("receiver idle after begin");

  // an abort status always comes with a cancel byte
  a_abort_can: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.done_res && res.status == ST_ABORT |->
      res.tx_valid && res.tx_byte == B_CAN)
    else $error("abort without cancel byte");

  // a payload write never shares a result with a send or a status
  a_write_alone: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.buf_write |-> !res.tx_valid && !res.done_res)
    else $error("payload write mixed with other result");

  // nothing is pushed into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> q_ready && cmd.ready)
    else $error("queue overflow");

endmodule

[hdl/xcr_front.sv]
`timescale 1ns / 1ps
// xcr_front: accepts command requests and classifies them into queue entries
// depends on xcr_pkg and xcr_cmd_if
module xcr_front
  import xcr_pkg::*;
(
  xcr_cmd_if.sink cmd,
  input  logic    q_ready,
  output logic    push,
  output item_t   entry
);

  // accept whenever the queue has room
  assign cmd.ready = q_ready;

  // opcode decode; unknown opcodes are accepted and dropped
  always_comb begin
    entry.kind = K_BYTE;
    entry.data = cmd.rx_byte;
    push       = cmd.valid && q_ready;
    unique case (cmd.opcode)
      OP_BYTE:   entry.kind = K_BYTE;
      OP_TICK:   entry.kind = K_TICK;
      OP_BEGIN:  entry.kind = K_BEGIN;
      OP_NEXT: begin
        entry.kind = K_NEXT;
        entry.data = cmd.expected_number;
      end
      OP_CANCEL: entry.kind = K_CANCEL;
      default:   push = 1'b0;
    endcase
  end

endmodule

[hdl/xcr_queue.sv]
`timescale 1ns / 1ps
// xcr_queue: short fifo of classified requests between front and engine
// depends on xcr_pkg
module xcr_queue
  import xcr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  not_full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head
);

  item_t          slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign not_full   = (count != QAW'(0) + (QAW+1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      if (push && !pop) begin
        count <= count + (QAW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QAW+1)'(1);
      end
    end
  end

endmodule

[hdl/xcr_engine.sv]
`timescale 1ns / 1ps
// xcr_engine: protocol state machine, crc and result register
// depends on xcr_pkg and xcr_res_if
module xcr_engine
  import xcr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      head_valid,
  input  item_t     head,
  output eng_stat_t stat,
  xcr_res_if.source res
);

  phase_t      phase, phase_next;
  logic        purge_then_c, purge_then_c_next;
  logic        begin_mode, begin_mode_next;
  logic [7:0]  awaited_number, awaited_number_next;
  logic [7:0]  got_number, got_number_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  crc_high, crc_high_next;
  logic [7:0]  retry_count, retry_count_next;
  logic [15:0] wait_timer, wait_timer_next;

  logic        res_valid;
  res_t        res_q, res_d;
  logic        res_load;

  logic        go;
  logic [7:0]  b;
  logic [16:0] tick_t;
  logic [15:0] limit;
  logic        tick_hit;
  logic        num_ok;
  logic        comp_ok;
  logic        crc_ok;
  logic        retry_ok;
  logic [7:0]  count_inc;
  logic        last_byte;
  logic        fail_a, fail_b;
  logic        abort_b;

  // byte-wise crc-16/xmodem, eight shift steps
  function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] d);
    logic [15:0] c;
    c = crc_in ^ {d, 8'h00};
    for (int j = 0; j < 8; j++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // take the head item when the result register is free
  assign go        = head_valid && (!res_valid || res.ready);
  assign b         = head.data;
  assign stat.pop  = go;
  assign stat.idle = (phase == PH_IDLE);

  // shared conditions
  assign limit     = (phase == PH_PURGE)    ? cfg.purge_timeout_ms :
                     (phase == PH_WAIT_SOH) ? cfg.packet_timeout_ms : cfg.data_timeout_ms;
  assign tick_t    = {1'b0, wait_timer} + 17'd1;
  assign tick_hit  = !(tick_t < {1'b0, limit});
  assign num_ok    = (b == awaited_number) || (b == awaited_number - 8'd1);
  assign comp_ok   = (({1'b0, b} + {1'b0, got_number}) == 9'h0ff);
  assign crc_ok    = ({crc_high, b} == running_crc);
  assign retry_ok  = (retry_count < cfg.retry_limit);
  assign count_inc = byte_count + 8'd1;
  assign last_byte = ({1'b0, count_inc} >= 9'(PAYLOAD_BYTES));

  // next phase
  always_comb begin
    phase_next = phase;
    fail_a     = 1'b0;
    if (go) begin
      unique case (head.kind)
        K_BYTE: begin
          unique case (phase)
            PH_IDLE, PH_PURGE: phase_next = phase;
            PH_WAIT_SOH: begin
              if (b == B_SOH) begin
                phase_next = PH_NUM;
              end else if (b == B_EOT || b == B_CAN) begin
                phase_next = PH_IDLE;
              end else begin
                fail_a = 1'b1;
              end
            end
            PH_NUM:      phase_next = num_ok ? PH_NUM_COMP : PH_IDLE;
            PH_NUM_COMP: begin
              if (comp_ok) begin
                phase_next = PH_PAYLOAD;
              end else begin
                fail_a = 1'b1;
              end
            end
            PH_PAYLOAD:  phase_next = last_byte ? PH_CRC_HI : PH_PAYLOAD;
            PH_CRC_HI:   phase_next = PH_CRC_LO;
            PH_CRC_LO: begin
              if (!crc_ok) begin
                fail_a = 1'b1;
              end else if (got_number == awaited_number || begin_mode) begin
                phase_next = PH_IDLE;
              end else begin
                phase_next = PH_WAIT_SOH;
              end
            end
            default:     phase_next = phase;
          endcase
        end
        K_TICK: begin
          if (phase != PH_IDLE && tick_hit) begin
            if (phase == PH_PURGE) begin
              phase_next = PH_WAIT_SOH;
            end else if (phase == PH_WAIT_SOH && begin_mode) begin
              phase_next = PH_IDLE;
            end else begin
              fail_a = 1'b1;
            end
          end
        end
        K_BEGIN:  phase_next = PH_PURGE;
        K_NEXT:   phase_next = PH_WAIT_SOH;
        K_CANCEL: phase_next = PH_IDLE;
        default:  phase_next = phase;
      endcase
      // a failure retries after a purge or gives up
      if (fail_a) begin
        phase_next = retry_ok ? PH_PURGE : PH_IDLE;
      end
    end
  end

  // datapath updates and result
  always_comb begin
    purge_then_c_next   = purge_then_c;
    begin_mode_next     = begin_mode;
    awaited_number_next = awaited_number;
    got_number_next     = got_number;
    byte_count_next     = byte_count;
    running_crc_next    = running_crc;
    crc_high_next       = crc_high;
    retry_count_next    = retry_count;
    wait_timer_next     = wait_timer;
    res_d               = '0;
    res_load            = 1'b0;
    fail_b              = 1'b0;
    abort_b             = 1'b0;
    if (go) begin
      unique case (head.kind)
        K_BYTE: begin
          if (phase != PH_IDLE) begin
            wait_timer_next = '0;
          end
          unique case (phase)
            PH_IDLE, PH_PURGE: res_load = 1'b0;
            PH_WAIT_SOH: begin
              if (b == B_SOH) begin
                byte_count_next  = '0;
                running_crc_next = '0;
              end else if (b == B_EOT) begin
                res_load       = 1'b1;
                res_d.tx_valid = 1'b1;
                res_d.tx_byte  = B_ACK;
                res_d.done_res = 1'b1;
                res_d.status   = ST_EOT;
              end else if (b == B_CAN) begin
                res_load       = 1'b1;
                res_d.done_res = 1'b1;
                res_d.status   = ST_CAN;
              end else begin
                fail_b = 1'b1;
              end
            end
            PH_NUM: begin
              if (num_ok) begin
                got_number_next = b;
              end else begin
                abort_b = 1'b1;
              end
            end
            PH_NUM_COMP: fail_b = !comp_ok;
            PH_PAYLOAD: begin
              res_load         = 1'b1;
              res_d.buf_write  = 1'b1;
              res_d.buf_index  = byte_count[6:0];
              res_d.buf_byte   = b;
              running_crc_next = crc_step(running_crc, b);
              byte_count_next  = count_inc;
            end
            PH_CRC_HI:   crc_high_next = b;
            PH_CRC_LO: begin
              if (!crc_ok) begin
                fail_b = 1'b1;
              end else if (got_number == awaited_number) begin
                res_load       = 1'b1;
                res_d.done_res = 1'b1;
                res_d.status   = ST_OK;
              end else if (begin_mode) begin
                abort_b = 1'b1;
              end else begin
                retry_count_next = '0;
                res_load         = 1'b1;
                res_d.tx_valid   = 1'b1;
                res_d.tx_byte    = B_ACK;
              end
            end
            default:     res_load = 1'b0;
          endcase
        end
        K_TICK: begin
          if (phase != PH_IDLE) begin
            if (!tick_hit) begin
              wait_timer_next = tick_t[15:0];
            end else begin
              wait_timer_next = '0;
              if (phase == PH_PURGE) begin
                res_load       = 1'b1;
                res_d.tx_valid = 1'b1;
                res_d.tx_byte  = purge_then_c ? B_C : B_NAK;
              end else if (phase == PH_WAIT_SOH && begin_mode) begin
                res_load       = 1'b1;
                res_d.done_res = 1'b1;
                res_d.status   = ST_INIT_TIMEOUT;
              end else begin
                fail_b = 1'b1;
              end
            end
          end
        end
        K_BEGIN: begin
          purge_then_c_next   = 1'b1;
          begin_mode_next     = 1'b1;
          awaited_number_next = 8'd1;
          retry_count_next    = '0;
          wait_timer_next     = '0;
        end
        K_NEXT: begin
          purge_then_c_next   = 1'b0;
          begin_mode_next     = 1'b0;
          awaited_number_next = b;
          retry_count_next    = '0;
          wait_timer_next     = '0;
          res_load            = 1'b1;
          res_d.tx_valid      = 1'b1;
          res_d.tx_byte       = B_ACK;
        end
        K_CANCEL: begin
          wait_timer_next = '0;
          res_load        = 1'b1;
          res_d.tx_valid  = 1'b1;
          res_d.tx_byte   = B_CAN;
        end
        default: res_load = 1'b0;
      endcase
      // retry with a purge, or abort once the retries are spent
      if (fail_b) begin
        if (retry_ok) begin
          retry_count_next  = retry_count + 8'd1;
          purge_then_c_next = 1'b0;
          wait_timer_next   = '0;
        end else begin
          abort_b = 1'b1;
        end
      end
      if (abort_b) begin
        res_load       = 1'b1;
        res_d          = '0;
        res_d.tx_valid = 1'b1;
        res_d.tx_byte  = B_CAN;
        res_d.done_res = 1'b1;
        res_d.status   = ST_ABORT;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      purge_then_c   <= 1'b0;
      begin_mode     <= 1'b0;
      awaited_number <= '0;
      got_number     <= '0;
      byte_count     <= '0;
      running_crc    <= '0;
      crc_high       <= '0;
      retry_count    <= '0;
      wait_timer     <= '0;
    end else begin
      phase          <= phase_next;
      purge_then_c   <= purge_then_c_next;
      begin_mode     <= begin_mode_next;
      awaited_number <= awaited_number_next;
      got_number     <= got_number_next;
      byte_count     <= byte_count_next;
      running_crc    <= running_crc_next;
      crc_high       <= crc_high_next;
      retry_count    <= retry_count_next;
      wait_timer     <= wait_timer_next;
    end
  end

  // result register, freed as the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (go && res_load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res_load) begin
      res_q <= res_d;
    end
  end

  assign res.valid     = res_valid;
  assign res.tx_valid  = res_q.tx_valid;
  assign res.tx_byte   = res_q.tx_byte;
  assign res.buf_write = res_q.buf_write;
  assign res.buf_index = res_q.buf_index;
  assign res.buf_byte  = res_q.buf_byte;
  assign res.done_res  = res_q.done_res;
  assign res.status    = res_q.status;

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking bench for xmodem_crc_receiver: reset values, directed requests, random sessions, long timeouts
// depends on xcr_pkg, xcr_ifs and the receiver rtl; predicts every result in the bench itself
module tb
  import xcr_pkg::*;
();

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_PRINTS    = 40;

  // opcodes that the block must ignore
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  xcr_cmd_if cmd_ch ();
  xcr_res_if res_ch ();

  xmodem_crc_receiver i_dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // bench copy of the receiver state and registers
  cfg_t        cfg_shadow;
  phase_t      rx_phase;
  bit          purge_sends_c;
  bit          in_begin;
  logic [7:0]  awaited_num;
  logic [7:0]  got_num;
  logic [7:0]  payload_count;
  logic [7:0]  crc_hi_byte;
  logic [7:0]  retries;
  logic [15:0] crc_acc;
  logic [15:0] quiet_ms;

  res_t        expected_replies[$];
  int unsigned errors;
  int unsigned cycle_count;
  int unsigned live_items;
  int          burst_left;

  // receiver stall pattern state
  int          ready_mode;
  int          ready_mode_left;
  int          ready_hold;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // crc-16/xmodem over one byte
  function automatic logic [15:0] crc16_xmodem(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int j = 0; j < 8; j++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // send can and finish with abort
  function automatic res_t abort_reply();
    res_t r;
    r = '0;
    r.tx_valid = 1'b1;
    r.tx_byte  = B_CAN;
    r.done_res = 1'b1;
    r.status   = ST_ABORT;
    rx_phase   = PH_IDLE;
    return r;
  endfunction

  // bad data or timeout: purge then nak, or abort once retries run out
  function automatic bit retry_or_abort(output res_t r);
    r = '0;
    if (retries < cfg_shadow.retry_limit) begin
      retries       = retries + 8'd1;
      rx_phase      = PH_PURGE;
      purge_sends_c = 1'b0;
      quiet_ms      = '0;
      return 1'b0;
    end
    r = abort_reply();
    return 1'b1;
  endfunction

  // expected result of one accepted request; returns 1 when a result is due
  function automatic bit protocol_step(input logic [2:0] op, input logic [7:0] b,
                                       input logic [7:0] num, output res_t r);
    logic [16:0] next_quiet;
    logic [15:0] wait_limit;
    logic [7:0]  prev_num;
    r = '0;
    prev_num = awaited_num - 8'd1;
    case (op)
      OP_BYTE: begin
        if (rx_phase == PH_IDLE) return 1'b0;
        quiet_ms = '0;
        case (rx_phase)
          PH_PURGE: return 1'b0;
          PH_WAIT_SOH: begin
            if (b == B_SOH) begin
              rx_phase      = PH_NUM;
              payload_count = '0;
              crc_acc       = '0;
              return 1'b0;
            end
            if (b == B_EOT) begin
              r.tx_valid = 1'b1;
              r.tx_byte  = B_ACK;
              r.done_res = 1'b1;
              r.status   = ST_EOT;
              rx_phase   = PH_IDLE;
              return 1'b1;
            end
            if (b == B_CAN) begin
              r.done_res = 1'b1;
              r.status   = ST_CAN;
              rx_phase   = PH_IDLE;
              return 1'b1;
            end
            return retry_or_abort(r);
          end
          PH_NUM: begin
            if (b == awaited_num || b == prev_num) begin
              got_num  = b;
              rx_phase = PH_NUM_COMP;
              return 1'b0;
            end
            r = abort_reply();
            return 1'b1;
          end
          PH_NUM_COMP: begin
            if (({1'b0, b} + {1'b0, got_num}) != 9'h0ff) return retry_or_abort(r);
            rx_phase = PH_PAYLOAD;
            return 1'b0;
          end
          PH_PAYLOAD: begin
            r.buf_write   = 1'b1;
            r.buf_index   = payload_count[6:0];
            r.buf_byte    = b;
            crc_acc       = crc16_xmodem(crc_acc, b);
            payload_count = payload_count + 8'd1;
            if (payload_count >= PAYLOAD_BYTES) rx_phase = PH_CRC_HI;
            return 1'b1;
          end
          PH_CRC_HI: begin
            crc_hi_byte = b;
            rx_phase    = PH_CRC_LO;
            return 1'b0;
          end
          default: begin
            if ({crc_hi_byte, b} != crc_acc) return retry_or_abort(r);
            if (got_num == awaited_num) begin
              r.done_res = 1'b1;
              r.status   = ST_OK;
              rx_phase   = PH_IDLE;
              return 1'b1;
            end
            if (in_begin) begin
              r = abort_reply();
              return 1'b1;
            end
            // repeated packet outside begin: ack and keep waiting
            retries    = '0;
            rx_phase   = PH_WAIT_SOH;
            r.tx_valid = 1'b1;
            r.tx_byte  = B_ACK;
            return 1'b1;
          end
        endcase
      end
      OP_TICK: begin
        if (rx_phase == PH_IDLE) return 1'b0;
        case (rx_phase)
          PH_PURGE:    wait_limit = cfg_shadow.purge_timeout_ms;
          PH_WAIT_SOH: wait_limit = cfg_shadow.packet_timeout_ms;
          default:     wait_limit = cfg_shadow.data_timeout_ms;
        endcase
        next_quiet = {1'b0, quiet_ms} + 17'd1;
        if (next_quiet < {1'b0, wait_limit}) begin
          quiet_ms = next_quiet[15:0];
          return 1'b0;
        end
        quiet_ms = '0;
        if (rx_phase == PH_PURGE) begin
          rx_phase   = PH_WAIT_SOH;
          r.tx_valid = 1'b1;
          r.tx_byte  = purge_sends_c ? B_C : B_NAK;
          return 1'b1;
        end
        if (rx_phase == PH_WAIT_SOH && in_begin) begin
          r.done_res = 1'b1;
          r.status   = ST_INIT_TIMEOUT;
          rx_phase   = PH_IDLE;
          return 1'b1;
        end
        return retry_or_abort(r);
      end
      OP_BEGIN: begin
        rx_phase      = PH_PURGE;
        purge_sends_c = 1'b1;
        in_begin      = 1'b1;
        awaited_num   = 8'd1;
        retries       = '0;
        quiet_ms      = '0;
        return 1'b0;
      end
      OP_NEXT: begin
        rx_phase      = PH_WAIT_SOH;
        purge_sends_c = 1'b0;
        in_begin      = 1'b0;
        awaited_num   = num;
        retries       = '0;
        quiet_ms      = '0;
        r.tx_valid    = 1'b1;
        r.tx_byte     = B_ACK;
        return 1'b1;
      end
      OP_CANCEL: begin
        rx_phase   = PH_IDLE;
        quiet_ms   = '0;
        r.tx_valid = 1'b1;
        r.tx_byte  = B_CAN;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // one line per mismatch, printing capped
  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_PRINTS) $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want) report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // one request on the command channel, sent in bursts with random gaps
  task automatic push_request(input logic [2:0] op, input logic [7:0] b, input logic [7:0] num);
    int   gap;
    bit   ignored;
    res_t r;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cmd_ch.valid           <= 1'b1;
    cmd_ch.opcode          <= op;
    cmd_ch.rx_byte         <= b;
    cmd_ch.expected_number <= num;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    ignored = (op > OP_CANCEL) || ((op == OP_BYTE || op == OP_TICK) && rx_phase == PH_IDLE);
    if (!ignored) live_items++;
    if (protocol_step(op, b, num, r)) expected_replies.push_back(r);
  endtask

  // wait until the block has nothing left in flight
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write: setup, access, then idle
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_registers(input int unsigned pk, input int unsigned dt,
                               input int unsigned pg, input int unsigned rl);
    settle();
    apb_write(REG_PACKET_TO, pk);
    apb_write(REG_DATA_TO, dt);
    apb_write(REG_PURGE_TO, pg);
    apb_write(REG_RETRY_LIM, rl);
    cfg_shadow.packet_timeout_ms = pk[15:0];
    cfg_shadow.data_timeout_ms   = dt[15:0];
    cfg_shadow.purge_timeout_ms  = pg[15:0];
    cfg_shadow.retry_limit       = rl[7:0];
  endtask

  function automatic logic [7:0] edge_value();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hff;
      2: return B_SOH;
      3: return B_EOT;
      4: return B_CAN;
      default: return 8'h80;
    endcase
  endfunction

  // awaited number mostly, the previous one or a stray number sometimes
  function automatic logic [7:0] pick_number();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return awaited_num;
    if (pick < 85) return awaited_num - 8'd1;
    return $urandom_range(0, 255);
  endfunction

  // one packet with optional damage; stops once the block leaves the packet
  task automatic send_packet(input logic [7:0] num, input bit bad_comp, input bit bad_crc);
    logic [15:0] crc;
    logic [7:0]  b;
    int unsigned ticks;
    int unsigned cut;
    crc = '0;
    cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, PAYLOAD_BYTES - 1) : PAYLOAD_BYTES;
    push_request(OP_BYTE, B_SOH, $urandom_range(0, 255));
    if (rx_phase != PH_NUM) return;
    push_request(OP_BYTE, num, $urandom_range(0, 255));
    if (rx_phase != PH_NUM_COMP) return;
    b = ~num;
    if (bad_comp) b = b ^ (8'h01 << $urandom_range(0, 7));
    push_request(OP_BYTE, b, $urandom_range(0, 255));
    if (rx_phase != PH_PAYLOAD) return;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      // truncated packet: leave the rest to the caller
      if (i == cut) return;
      // command in the middle of a packet restarts the receive
      if ($urandom_range(0, 399) == 0) begin
        if ($urandom_range(0, 1) == 0) push_request(OP_BEGIN, 8'h00, 8'h00);
        else push_request(OP_NEXT, 8'h00, $urandom_range(0, 255));
        return;
      end
      // quiet ticks short of the data timeout
      if (cfg_shadow.data_timeout_ms > 1 && $urandom_range(0, 29) == 0) begin
        ticks = $urandom_range(1, (cfg_shadow.data_timeout_ms > 6) ? 5 :
                                  cfg_shadow.data_timeout_ms - 1);
        repeat (ticks) push_request(OP_TICK, $urandom_range(0, 255), $urandom_range(0, 255));
      end
      b = ($urandom_range(0, 9) == 0) ? edge_value() : $urandom_range(0, 255);
      crc = crc16_xmodem(crc, b);
      push_request(OP_BYTE, b, $urandom_range(0, 255));
    end
    if (bad_crc) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    push_request(OP_BYTE, crc[15:8], $urandom_range(0, 255));
    push_request(OP_BYTE, crc[7:0], $urandom_range(0, 255));
  endtask

  // random sessions steered by the predicted phase
  task automatic run_sessions(input int unsigned budget);
    int unsigned first;
    int unsigned pick;
    logic [7:0]  num;
    first = live_items;
    while (live_items - first < budget) begin
      pick = $urandom_range(0, 99);
      case (rx_phase)
        PH_IDLE: begin
          if (pick < 10) begin
            // dropped while idle
            push_request($urandom_range(0, 1) ? OP_BYTE : OP_TICK,
                         $urandom_range(0, 255), $urandom_range(0, 255));
          end else if (pick < 14) begin
            push_request($urandom_range(OP_SPARE_LO, OP_SPARE_HI),
                         $urandom_range(0, 255), $urandom_range(0, 255));
          end else if (pick < 50) begin
            push_request(OP_BEGIN, $urandom_range(0, 255), $urandom_range(0, 255));
          end else begin
            num = ($urandom_range(0, 3) == 0) ? edge_value() : $urandom_range(0, 255);
            push_request(OP_NEXT, $urandom_range(0, 255), num);
          end
        end
        PH_PURGE: begin
          if (pick < 15) push_request(OP_BYTE, $urandom_range(0, 255), $urandom_range(0, 255));
          else if (pick < 17) push_request(OP_CANCEL, $urandom_range(0, 255), 8'h00);
          else push_request(OP_TICK, $urandom_range(0, 255), $urandom_range(0, 255));
        end
        PH_WAIT_SOH: begin
          if (pick < 60) begin
            send_packet(pick_number(), $urandom_range(0, 19) == 0, $urandom_range(0, 14) == 0);
          end else if (pick < 67) begin
            push_request(OP_BYTE, B_EOT, $urandom_range(0, 255));
          end else if (pick < 71) begin
            push_request(OP_BYTE, B_CAN, $urandom_range(0, 255));
          end else if (pick < 79) begin
            push_request(OP_BYTE, $urandom_range(0, 255), $urandom_range(0, 255));
          end else if (pick < 92) begin
            push_request(OP_TICK, $urandom_range(0, 255), $urandom_range(0, 255));
          end else if (pick < 95) begin
            push_request(OP_NEXT, $urandom_range(0, 255), $urandom_range(0, 255));
          end else if (pick < 97) begin
            push_request(OP_CANCEL, $urandom_range(0, 255), $urandom_range(0, 255));
          end else begin
            push_request($urandom_range(OP_SPARE_LO, OP_SPARE_HI),
                         $urandom_range(0, 255), $urandom_range(0, 255));
          end
        end
        default: begin
          // left inside a packet: mostly wait for the data timeout
          if (pick < 80) push_request(OP_TICK, $urandom_range(0, 255), $urandom_range(0, 255));
          else push_request(OP_BYTE, $urandom_range(0, 255), $urandom_range(0, 255));
        end
      endcase
    end
  endtask

  // registers at reset values: begin, first packet, next request, end
  task automatic test_reset_values();
    push_request(OP_BEGIN, 8'h00, 8'h00);
    while (rx_phase == PH_PURGE) push_request(OP_TICK, 8'h00, 8'h00);
    send_packet(awaited_num, 1'b0, 1'b0);
    push_request(OP_NEXT, 8'h00, 8'h02);
    push_request(OP_BYTE, B_EOT, 8'h00);
  endtask

  // short directed sequence over each special case
  task automatic test_directed();
    set_registers(1, 1, 1, 1);
    // idle drops and spare opcodes
    push_request(OP_BYTE, 8'h00, 8'h00);
    push_request(OP_TICK, 8'hff, 8'hff);
    push_request(OP_SPARE_LO, 8'h00, 8'h00);
    push_request(OP_SPARE_HI, 8'hff, 8'hff);
    // begin, byte during purge, 'C', then initial timeout
    push_request(OP_BEGIN, 8'h00, 8'h00);
    push_request(OP_BYTE, 8'hff, 8'h00);
    push_request(OP_TICK, 8'h00, 8'h00);
    push_request(OP_TICK, 8'h00, 8'h00);
    // garbage in place of soh, nak after purge
    push_request(OP_NEXT, 8'h00, 8'h00);
    push_request(OP_BYTE, 8'h7e, 8'h00);
    push_request(OP_TICK, 8'h00, 8'h00);
    // previous number wraps to 0xff, then a bad complement with retries used up
    push_request(OP_BYTE, B_SOH, 8'h00);
    push_request(OP_BYTE, 8'hff, 8'h00);
    push_request(OP_BYTE, 8'h01, 8'h00);
    // number neither awaited nor previous
    push_request(OP_NEXT, 8'h00, 8'h05);
    push_request(OP_BYTE, B_SOH, 8'h00);
    push_request(OP_BYTE, 8'h07, 8'h00);
    // end of transfer and sender cancel
    push_request(OP_NEXT, 8'h00, 8'h80);
    push_request(OP_BYTE, B_EOT, 8'h00);
    push_request(OP_NEXT, 8'h00, 8'hff);
    push_request(OP_BYTE, B_CAN, 8'h00);
    // timeout outside begin counts as a retry, then abort
    push_request(OP_NEXT, 8'h00, 8'h01);
    push_request(OP_TICK, 8'h00, 8'h00);
    push_request(OP_TICK, 8'h00, 8'h00);
    push_request(OP_TICK, 8'h00, 8'h00);
    // cancel while busy
    push_request(OP_BEGIN, 8'h00, 8'h00);
    push_request(OP_CANCEL, 8'h00, 8'h00);
  endtask

  task automatic test_random_sessions();
    set_registers($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4),
                  $urandom_range(0, 3));
    run_sessions(40);
    set_registers($urandom_range(2, 8), $urandom_range(2, 8), $urandom_range(1, 3), 255);
    run_sessions(40);
    set_registers(1, 1, 1, 0);
    run_sessions(40);
  endtask

  // largest timeouts: ticks never run out, a repeated packet is acked
  task automatic test_long_timeouts();
    set_registers(65535, 65535, 65535, 255);
    push_request(OP_NEXT, 8'h00, 8'h2b);
    repeat (4) push_request(OP_TICK, 8'h00, 8'h00);
    send_packet(8'h2a, 1'b0, 1'b0);
    push_request(OP_BEGIN, 8'h00, 8'h00);
    repeat (3) push_request(OP_TICK, 8'h00, 8'h00);
    push_request(OP_CANCEL, 8'h00, 8'h00);
    set_registers(65535, 65535, 65535, 0);
    push_request(OP_NEXT, 8'h00, 8'h00);
    push_request(OP_BYTE, 8'h55, 8'h00);
  endtask

  // stimulus and verdict
  initial begin
    rst                    = 1'b1;
    cmd_ch.valid           = 1'b0;
    cmd_ch.opcode          = OP_BYTE;
    cmd_ch.rx_byte         = 8'h00;
    cmd_ch.expected_number = 8'h00;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    cfg_shadow.packet_timeout_ms = 16'd1000;
    cfg_shadow.data_timeout_ms   = 16'd100;
    cfg_shadow.purge_timeout_ms  = 16'd100;
    cfg_shadow.retry_limit       = 8'd10;
    rx_phase      = PH_IDLE;
    purge_sends_c = 1'b0;
    in_begin      = 1'b0;
    awaited_num   = '0;
    got_num       = '0;
    payload_count = '0;
    crc_hi_byte   = '0;
    retries       = '0;
    crc_acc       = '0;
    quiet_ms      = '0;
    errors        = 0;
    live_items    = 0;
    burst_left    = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_directed();
    test_random_sessions();
    test_long_timeouts();
    settle();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // receiver stall pattern: always ready, random, or long stalls
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready    <= 1'b0;
      ready_mode      <= 0;
      ready_mode_left <= 100;
      ready_hold      <= 0;
    end else begin
      if (ready_mode_left == 0) begin
        ready_mode      <= $urandom_range(0, 2);
        ready_mode_left <= $urandom_range(50, 400);
      end else begin
        ready_mode_left <= ready_mode_left - 1;
      end
      case (ready_mode)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if (ready_hold == 0) begin
            res_ch.ready <= !res_ch.ready;
            ready_hold   <= res_ch.ready ? $urandom_range(1, 24) : $urandom_range(1, 8);
          end else begin
            ready_hold <= ready_hold - 1;
          end
        end
      endcase
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.tx_valid  = res_ch.tx_valid;
      got.tx_byte   = res_ch.tx_byte;
      got.buf_write = res_ch.buf_write;
      got.buf_index = res_ch.buf_index;
      got.buf_byte  = res_ch.buf_byte;
      got.done_res  = res_ch.done_res;
      got.status    = res_ch.status;
      if (expected_replies.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = expected_replies.pop_front();
        check_field("tx_valid", got.tx_valid, want.tx_valid);
        check_field("tx_byte", got.tx_byte, want.tx_byte);
        check_field("buf_write", got.buf_write, want.buf_write);
        check_field("buf_index", got.buf_index, want.buf_index);
        check_field("buf_byte", got.buf_byte, want.buf_byte);
        check_field("done_res", got.done_res, want.done_res);
        check_field("status", got.status, want.status);
      end
    end
  end

endmodule
